@@ hdl/assert_macros.svh @@
// ------------------------------------------------------------------------------------------
// assertion macros
// concurrent checks that compile away when SYNTHESIS is set
// ------------------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hdl/jafpe_pkg.sv @@
// ------------------------------------------------------------------------------------------
// jafpe_pkg
// shared types, constants and helpers of the joystick port encoder
// ------------------------------------------------------------------------------------------
`default_nettype none

package jafpe_pkg;

   localparam int NUM_BUTTONS_DEFAULT = 8;
   localparam int MAX_BUTTONS         = 8;
   localparam int MODE_W              = 4;
   localparam int COUNT_W             = 9;
   localparam int PORT_W              = 6;
   localparam int CSR_DATA_W          = 32;
   localparam int CSR_INDEX_W         = 3;

   localparam logic [7:0] CODE_BASE = 8'h70;
   localparam logic [7:0] CODE_LAST = 8'h75;

   localparam logic [COUNT_W-1:0] PHASE_BIT = 9'h100;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_RAPID_MODES   = 3'd0,
      REG_UP_CODE       = 3'd1,
      REG_DOWN_CODE     = 3'd2,
      REG_LEFT_CODE     = 3'd3,
      REG_RIGHT_CODE    = 3'd4,
      REG_CENTER_CODE   = 3'd5,
      REG_BUTTON_A_CODE = 3'd6,
      REG_BUTTON_B_CODE = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [7:0] up;
      logic [7:0] down;
      logic [7:0] left;
      logic [7:0] right;
      logic [7:0] center;
      logic [7:0] button_a;
      logic [7:0] button_b;
   } codes_type;

   // half-period for an autofire setting, zero when autofire is off
   function automatic logic [7:0] period_of(logic [MODE_W-1:0] mode);
      case (mode)
         4'd1:    return 8'd25;
         4'd2:    return 8'd12;
         4'd3:    return 8'd8;
         4'd4:    return 8'd6;
         4'd5:    return 8'd5;
         4'd6:    return 8'd4;
         4'd7:    return 8'd3;
         4'd8:    return 8'd2;
         4'd9:    return 8'd1;
         default: return 8'd0;
      endcase
   endfunction

   // codes in the mapped window select one port bit, others select none
   function automatic logic [PORT_W-1:0] code_to_bit(logic [7:0] code);
      logic [7:0] offset;
      offset = code - CODE_BASE;
      if (code < CODE_BASE || code > CODE_LAST) begin
         return '0;
      end
      return PORT_W'(1) << offset[2:0];
   endfunction

endpackage

`default_nettype wire

@@ hdl/jafpe_req_if.sv @@
// ------------------------------------------------------------------------------------------
// jafpe_req_if
// poll tick channel: direction nibble, button mask and connected flag
// ------------------------------------------------------------------------------------------
`default_nettype none

interface jafpe_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] direction;
   logic [7:0] pressed;
   logic       connected;

   modport source (output valid, direction, pressed, connected, input ready);
   modport sink   (input valid, direction, pressed, connected, output ready);
endinterface

`default_nettype wire

@@ hdl/jafpe_rsp_if.sv @@
// ------------------------------------------------------------------------------------------
// jafpe_rsp_if
// result channel: port byte and button mask after autofire
// ------------------------------------------------------------------------------------------
`default_nettype none

interface jafpe_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] port_byte;
   logic [7:0] buttons_after_rapid;

   modport source (output valid, port_byte, buttons_after_rapid, input ready);
   modport sink   (input valid, port_byte, buttons_after_rapid, output ready);
endinterface

`default_nettype wire

@@ hdl/joystick_autofire_port_encoder.sv @@
// ------------------------------------------------------------------------------------------
// joystick_autofire_port_encoder
// joystick poll encoder with per-button autofire and programmable port codes
// ------------------------------------------------------------------------------------------
// One poll word is taken per clock cycle unless the output stalls. A word is held in an
// input register and passes through the autofire counter bank and the code mapping in a
// single register-to-register step into the result register. The counter bank allows this
// rate by updating every button in parallel on that step; the request ready follows the
// result ready combinationally when both registers are full. Users must write configuration
// registers through the csr port while the block is idle; the block does not enforce it.
`default_nettype none

`include "assert_macros.svh"

module joystick_autofire_port_encoder
   import jafpe_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   jafpe_req_if.sink                   req_ch,
   jafpe_rsp_if.source                 rsp_ch,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic                  in_valid_ff;
   logic [3:0]            dir_ff;
   logic [7:0]            pressed_ff;
   logic                  conn_ff;
   logic                  rsp_valid_ff;
   logic [PORT_W-1:0]     rsp_port_ff;
   logic [7:0]            rsp_buttons_ff;
   logic [CSR_DATA_W-1:0] rapid_modes_ff;
   codes_type             codes_ff;
   logic                  advance;
   logic [7:0]            buttons;
   logic [PORT_W-1:0]     port_byte;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
      if (req_ch.valid && req_ch.ready) begin
         dir_ff     <= req_ch.direction;
         pressed_ff <= req_ch.pressed;
         conn_ff    <= req_ch.connected;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_port_ff    <= port_byte;
         rsp_buttons_ff <= buttons;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rapid_modes_ff    <= '0;
         codes_ff.up       <= 8'h70;
         codes_ff.down     <= 8'h71;
         codes_ff.left     <= 8'h72;
         codes_ff.right    <= 8'h73;
         codes_ff.center   <= 8'h00;
         codes_ff.button_a <= 8'h74;
         codes_ff.button_b <= 8'h75;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_RAPID_MODES:   rapid_modes_ff    <= csr_wdata;
            REG_UP_CODE:       codes_ff.up       <= csr_wdata[7:0];
            REG_DOWN_CODE:     codes_ff.down     <= csr_wdata[7:0];
            REG_LEFT_CODE:     codes_ff.left     <= csr_wdata[7:0];
            REG_RIGHT_CODE:    codes_ff.right    <= csr_wdata[7:0];
            REG_CENTER_CODE:   codes_ff.center   <= csr_wdata[7:0];
            REG_BUTTON_A_CODE: codes_ff.button_a <= csr_wdata[7:0];
            REG_BUTTON_B_CODE: codes_ff.button_b <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   jafpe_rapid #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_rapid (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .connected   (conn_ff),
      .pressed     (pressed_ff),
      .rapid_modes (rapid_modes_ff),
      .buttons     (buttons)
   );

   jafpe_encode u_encode (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .connected (conn_ff),
      .direction (dir_ff),
      .buttons   (buttons[3:0]),
      .codes     (codes_ff),
      .port_byte (port_byte)
   );

   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.port_byte           = rsp_port_ff;
   assign rsp_ch.buttons_after_rapid = rsp_buttons_ff;

   // a stalled word stays in the input register
   `ASSERT_NEXT(a_word_kept, clock, reset, in_valid_ff && !advance, in_valid_ff)
   `ASSERT_ALWAYS(a_no_phantom_buttons, clock, reset,
                  !rsp_valid_ff || ((rsp_buttons_ff >> NUM_BUTTONS) == 8'd0))

endmodule

`default_nettype wire

@@ hdl/jafpe_rapid.sv @@
// ------------------------------------------------------------------------------------------
// jafpe_rapid
// per-button autofire counters and phase masking of the button mask
// ------------------------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module jafpe_rapid
   import jafpe_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic                  connected,
   input  wire logic [MAX_BUTTONS-1:0] pressed,
   input  wire logic [CSR_DATA_W-1:0] rapid_modes,
   output logic      [MAX_BUTTONS-1:0] buttons
);

   logic [NUM_BUTTONS-1:0][COUNT_W-1:0] counter_ff;
   logic [NUM_BUTTONS-1:0][COUNT_W-1:0] counter_in;
   logic [NUM_BUTTONS-1:0]              live;

   for (genvar g = 0; g < NUM_BUTTONS; g++) begin : gen_btn
      logic [MODE_W-1:0]  mode;
      logic [COUNT_W-1:0] period;
      logic [COUNT_W-1:0] dec;
      logic [COUNT_W-1:0] nxt;
      logic               active;

      assign mode   = rapid_modes[MODE_W*g +: MODE_W];
      assign period = {1'b0, period_of(mode)};
      assign active = pressed[g] && (period != '0);
      assign dec    = counter_ff[g] - COUNT_W'(1);

      always_comb begin
         if (!active) begin
            nxt = '0;
         end else if (counter_ff[g] == '0) begin
            nxt = period;
         end else if (dec[7:0] == 8'd0) begin
            // half-period done: reload and flip the phase
            nxt = (dec + period) ^ PHASE_BIT;
         end else begin
            nxt = dec;
         end
      end

      // counters hold while the stick is unplugged
      assign counter_in[g] = connected ? nxt : counter_ff[g];
      assign live[g]       = connected && pressed[g] && !(active && nxt[COUNT_W-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
      end else if (step) begin
         counter_ff <= counter_in;
      end
   end

   assign buttons = MAX_BUTTONS'(live);

   `ASSERT_NEXT(a_hold_unplugged, clock, reset, step && !connected, $stable(counter_ff))
   `ASSERT_ALWAYS(a_mask_only_clears, clock, reset,
                  (buttons & ~pressed) == '0)

endmodule

`default_nettype wire

@@ hdl/jafpe_encode.sv @@
// ------------------------------------------------------------------------------------------
// jafpe_encode
// maps direction, centre event and buttons to the six-bit port byte
// ------------------------------------------------------------------------------------------
`default_nettype none

module jafpe_encode
   import jafpe_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic              connected,
   input  wire logic [3:0]        direction,
   input  wire logic [3:0]        buttons,
   input  wire codes_type         codes,
   output logic      [PORT_W-1:0] port_byte
);

   logic [3:0] prev_dir_ff;
   logic [3:0] dir;
   logic       centre;

   assign dir    = connected ? direction : 4'd0;
   assign centre = (dir == 4'd0) && (prev_dir_ff != 4'd0);

   always_comb begin
      port_byte = '0;
      if (dir[0])           port_byte |= code_to_bit(codes.up);
      if (dir[1])           port_byte |= code_to_bit(codes.down);
      if (dir[2])           port_byte |= code_to_bit(codes.left);
      if (dir[3])           port_byte |= code_to_bit(codes.right);
      if (centre)           port_byte |= code_to_bit(codes.center);
      if (buttons[0] || buttons[2]) port_byte |= code_to_bit(codes.button_a);
      if (buttons[1] || buttons[3]) port_byte |= code_to_bit(codes.button_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_dir_ff <= '0;
      end else if (step) begin
         prev_dir_ff <= dir;
      end
   end

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ------------------------------------------------------------------------------------------
// tb_top
// self-checking bench for the joystick port encoder with per-button autofire
// ------------------------------------------------------------------------------------------
// Poll words go in through the request channel in bursts with random gaps. The result
// channel stalls on changing patterns, and once holds off long enough to back up the input.
// Each accepted poll word is run through a local predictor of the autofire counters and the
// code mapping. Each result word is then checked against the oldest prediction. Directed
// tests cover the field extremes, unmapped codes, the centre event, disconnection and
// autofire settings above nine. Random phases then reprogram every register and send long
// held-button runs that let the counters wrap.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import jafpe_pkg::*;

   localparam int NUM_BUTTONS     = NUM_BUTTONS_DEFAULT;
   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 130;
   localparam int HOLD_CYCLES     = 80;
   localparam int DRAIN_LIMIT     = 4000;
   localparam int IDLE_CYCLES     = 4;
   localparam int MAX_PRINTS      = 30;

   localparam logic [7:0] BUTTON_MASK = 8'((1 << NUM_BUTTONS) - 1);
   // half-period per autofire setting, setting 0 at the bottom byte
   localparam logic [79:0] HALF_TICKS =
      {8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd8, 8'd12, 8'd25, 8'd0};

   typedef struct packed {
      logic [PORT_W-1:0] port;
      logic [7:0]        buttons;
   } port_word_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   jafpe_req_if req_ch ();
   jafpe_rsp_if rsp_ch ();

   joystick_autofire_port_encoder #(
      .NUM_BUTTONS(NUM_BUTTONS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [31:0]        autofire_modes;
   codes_type          port_codes;
   logic [COUNT_W-1:0] fire_count [MAX_BUTTONS];
   logic [3:0]         last_direction;

   port_word_type expected_port_words [$];
   int            error_count      = 0;
   int            burst_left       = 0;
   bit            sender_steady    = 1'b0;
   bit            hold_off_request = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(5_000_000);
      $display("== FAIL ==");
      $finish;
   end

   task automatic report_mismatch(input string what);
      if (error_count < MAX_PRINTS) begin
         $display("mismatch at %0t ns: %s", $time, what);
      end
      error_count++;
   endtask

   function automatic logic [PORT_W-1:0] port_bit_for(input logic [7:0] code);
      if (code >= CODE_BASE && code <= CODE_LAST) begin
         return PORT_W'(1) << (code - CODE_BASE);
      end
      return '0;
   endfunction

   // advances the autofire counters and the centre tracking by one poll tick
   function automatic port_word_type encode_poll_tick(input logic [3:0] dir_in,
                                                      input logic [7:0] btn_in,
                                                      input logic       conn);
      logic [3:0]         dir;
      logic [7:0]         live;
      logic [3:0]         mode;
      logic [7:0]         half;
      logic [COUNT_W-1:0] count;
      logic [PORT_W-1:0]  port;
      port_word_type      word;
      dir  = conn ? dir_in : 4'h0;
      live = '0;
      port = '0;
      if (conn) begin
         live = btn_in & BUTTON_MASK;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            mode = autofire_modes[4*i +: 4];
            if (live[i] && mode >= 4'd1 && mode <= 4'd9) begin
               half  = HALF_TICKS[8*mode +: 8];
               count = fire_count[i];
               if (count == '0) begin
                  count = COUNT_W'(half);
               end else begin
                  count = count - 1'b1;
                  if (count[7:0] == 8'h00) begin
                     count    = count + COUNT_W'(half);
                     count[8] = ~count[8];
                  end
               end
               // phase bit set hides the press
               if (count[8]) begin
                  live[i] = 1'b0;
               end
               fire_count[i] = count;
            end else begin
               fire_count[i] = '0;
            end
         end
      end
      if (dir[0]) port |= port_bit_for(port_codes.up);
      if (dir[1]) port |= port_bit_for(port_codes.down);
      if (dir[2]) port |= port_bit_for(port_codes.left);
      if (dir[3]) port |= port_bit_for(port_codes.right);
      if (dir == 4'h0 && last_direction != 4'h0) port |= port_bit_for(port_codes.center);
      last_direction = dir;
      if (live[0] || live[2]) port |= port_bit_for(port_codes.button_a);
      if (live[1] || live[3]) port |= port_bit_for(port_codes.button_b);
      word.port    = port;
      word.buttons = live;
      return word;
   endfunction

   always @(posedge clock) begin : word_monitor
      port_word_type want;
      port_word_type predicted;
      if (reset) begin
         autofire_modes       = '0;
         port_codes.up        = CODE_BASE;
         port_codes.down      = CODE_BASE + 8'd1;
         port_codes.left      = CODE_BASE + 8'd2;
         port_codes.right     = CODE_BASE + 8'd3;
         port_codes.center    = 8'h00;
         port_codes.button_a  = CODE_BASE + 8'd4;
         port_codes.button_b  = CODE_LAST;
         last_direction       = 4'h0;
         for (int i = 0; i < MAX_BUTTONS; i++) begin
            fire_count[i] = '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               REG_RAPID_MODES:   autofire_modes      = csr_wdata;
               REG_UP_CODE:       port_codes.up       = csr_wdata[7:0];
               REG_DOWN_CODE:     port_codes.down     = csr_wdata[7:0];
               REG_LEFT_CODE:     port_codes.left     = csr_wdata[7:0];
               REG_RIGHT_CODE:    port_codes.right    = csr_wdata[7:0];
               REG_CENTER_CODE:   port_codes.center   = csr_wdata[7:0];
               REG_BUTTON_A_CODE: port_codes.button_a = csr_wdata[7:0];
               REG_BUTTON_B_CODE: port_codes.button_b = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_port_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word port=%h buttons=%h",
                                         rsp_ch.port_byte, rsp_ch.buttons_after_rapid));
            end else begin
               want = expected_port_words.pop_front();
               if (rsp_ch.port_byte !== want.port) begin
                  report_mismatch($sformatf("port_byte got %h want %h",
                                            rsp_ch.port_byte, want.port));
               end
               if (rsp_ch.buttons_after_rapid !== want.buttons) begin
                  report_mismatch($sformatf("buttons_after_rapid got %h want %h",
                                            rsp_ch.buttons_after_rapid, want.buttons));
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            predicted = encode_poll_tick(req_ch.direction, req_ch.pressed, req_ch.connected);
            expected_port_words.insert(expected_port_words.size(), predicted);
         end
      end
   end

   // result side: ready follows a 16-slot pattern that is redrawn each time round
   initial begin : result_sink
      logic [15:0] stall_pattern;
      int          slot;
      int          hold_left;
      rsp_ch.ready  = 1'b0;
      stall_pattern = '1;
      slot          = 0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) begin
               @(negedge clock);
            end
         end
         if (slot == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pattern = '1;
               1: stall_pattern = 16'($urandom);
               2: stall_pattern = 16'hffff << $urandom_range(1, 12);
               default: stall_pattern = ~(16'h1 << $urandom_range(0, 15));
            endcase
            stall_pattern[0] = 1'b1;
         end
         rsp_ch.ready <= stall_pattern[slot];
         slot = (slot + 1) % 16;
      end
   end

   task automatic send_tick(input logic [3:0] dir, input logic [7:0] btn, input logic conn);
      int gap;
      @(negedge clock);
      if (!sender_steady) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         burst_left--;
      end
      req_ch.valid     <= 1'b1;
      req_ch.direction <= dir;
      req_ch.pressed   <= btn;
      req_ch.connected <= conn;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   task automatic close_writes();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // drop valid and wait until every predicted word has come back or the drain limit runs out
   task automatic settle();
      int waited;
      @(negedge clock);
      req_ch.valid <= 1'b0;
      waited = 0;
      while (expected_port_words.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   // mostly mapped codes, sometimes 00, ff, the codes just outside the window or anything at all
   function automatic logic [7:0] pick_code();
      case ($urandom_range(0, 9))
         7:       return ($urandom_range(0, 1) != 0) ? 8'h00 : 8'hff;
         8:       return ($urandom_range(0, 1) != 0) ? CODE_BASE - 8'd1 : CODE_LAST + 8'd1;
         9:       return 8'($urandom);
         default: return CODE_BASE + 8'($urandom_range(0, 5));
      endcase
   endfunction

   task automatic test_default_codes();
      send_tick(4'h1, 8'h00, 1'b1);
      send_tick(4'h2, 8'h00, 1'b1);
      send_tick(4'h4, 8'h00, 1'b1);
      send_tick(4'h8, 8'h00, 1'b1);
      // centre event with the unmapped reset centre code
      send_tick(4'h0, 8'h00, 1'b1);
      send_tick(4'hf, 8'hff, 1'b1);
      send_tick(4'hf, 8'hff, 1'b0);
      send_tick(4'h0, 8'h00, 1'b1);
      settle();
   endtask

   task automatic test_code_window();
      write_reg(REG_UP_CODE,       {24'($urandom), 8'hff});
      write_reg(REG_DOWN_CODE,     {24'($urandom), 8'h00});
      write_reg(REG_LEFT_CODE,     {24'h0, CODE_BASE - 8'd1});
      write_reg(REG_RIGHT_CODE,    {24'h0, CODE_LAST + 8'd1});
      write_reg(REG_CENTER_CODE,   {24'hffffff, CODE_LAST});
      write_reg(REG_BUTTON_A_CODE, {24'h0, CODE_BASE});
      write_reg(REG_BUTTON_B_CODE, {24'h0, CODE_BASE + 8'd2});
      close_writes();
      send_tick(4'hf, 8'h0f, 1'b1);
      send_tick(4'h0, 8'h00, 1'b1);
      send_tick(4'h5, 8'hf0, 1'b1);
      // pulling the plug reads as a return to centre
      send_tick(4'h5, 8'h05, 1'b0);
      send_tick(4'h3, 8'h0a, 1'b1);
      settle();
   endtask

   task automatic test_autofire_directed();
      // settings 5, 8, off above nine, 1, 15, 0, 10, 9 across buttons 0..7
      write_reg(REG_RAPID_MODES, 32'h9a0f_1b85);
      close_writes();
      repeat (8) send_tick(4'h0, 8'hff, 1'b1);
      // counters hold while disconnected
      send_tick(4'h2, 8'hff, 1'b0);
      repeat (3) send_tick(4'h0, 8'hff, 1'b1);
      send_tick(4'h0, 8'h00, 1'b1);
      settle();
   endtask

   task automatic test_input_stall();
      sender_steady    = 1'b1;
      hold_off_request = 1'b1;
      repeat (24) send_tick(4'($urandom), 8'($urandom), 1'b1);
      sender_steady = 1'b0;
      settle();
   endtask

   task automatic test_random_phases();
      logic [31:0] modes;
      logic [7:0]  held_btn;
      logic [3:0]  held_dir;
      logic [3:0]  dir;
      logic [7:0]  btn;
      logic        conn;
      logic [7:0]  fixed_code;
      int          sent;
      int          run_len;
      bit          noisy;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: modes = 32'h0000_0000;
            1: modes = 32'hffff_ffff;
            2: modes = 32'h9999_9999;
            3: modes = 32'h1111_1111;
            default: begin
               for (int n = 0; n < 8; n++) begin
                  modes[4*n +: 4] = 4'($urandom_range(0, 11));
                  if (modes[4*n +: 4] > 4'd9) modes[4*n +: 4] = 4'($urandom_range(10, 15));
               end
            end
         endcase
         fixed_code = (phase == 0) ? CODE_BASE : (phase == 1) ? CODE_LAST : 8'hff;
         write_reg(REG_RAPID_MODES, modes);
         if (phase < 3) begin
            write_reg(REG_UP_CODE,       {24'($urandom), fixed_code});
            write_reg(REG_DOWN_CODE,     {24'($urandom), fixed_code});
            write_reg(REG_LEFT_CODE,     {24'($urandom), fixed_code});
            write_reg(REG_RIGHT_CODE,    {24'($urandom), fixed_code});
            write_reg(REG_CENTER_CODE,   {24'($urandom), fixed_code});
            write_reg(REG_BUTTON_A_CODE, {24'($urandom), fixed_code});
            write_reg(REG_BUTTON_B_CODE, {24'($urandom), fixed_code});
         end else begin
            write_reg(REG_UP_CODE,       {24'($urandom), pick_code()});
            write_reg(REG_DOWN_CODE,     {24'($urandom), pick_code()});
            write_reg(REG_LEFT_CODE,     {24'($urandom), pick_code()});
            write_reg(REG_RIGHT_CODE,    {24'($urandom), pick_code()});
            write_reg(REG_CENTER_CODE,   {24'($urandom), pick_code()});
            write_reg(REG_BUTTON_A_CODE, {24'($urandom), pick_code()});
            write_reg(REG_BUTTON_B_CODE, {24'($urandom), pick_code()});
         end
         close_writes();
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            // long held runs let the slow settings wrap their phase bit
            run_len  = $urandom_range(1, 90);
            if (run_len > ITEMS_PER_PHASE - sent) run_len = ITEMS_PER_PHASE - sent;
            noisy    = ($urandom_range(0, 9) == 0);
            held_btn = 8'($urandom);
            held_dir = 4'($urandom);
            for (int k = 0; k < run_len; k++) begin
               if (noisy) begin
                  dir  = 4'($urandom);
                  btn  = 8'($urandom);
                  conn = 1'($urandom);
               end else begin
                  if ($urandom_range(0, 15) == 0) held_btn ^= 8'(1 << $urandom_range(0, 7));
                  if ($urandom_range(0, 7) == 0) begin
                     held_dir = ($urandom_range(0, 1) != 0) ? 4'h0 : 4'($urandom);
                  end
                  dir  = held_dir;
                  btn  = held_btn;
                  conn = ($urandom_range(0, 24) != 0);
               end
               send_tick(dir, btn, conn);
               sent++;
            end
         end
         settle();
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = REG_RAPID_MODES;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.direction = 4'h0;
      req_ch.pressed   = 8'h00;
      req_ch.connected = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_codes();
      test_code_window();
      test_autofire_directed();
      test_input_stall();
      test_random_phases();

      if (expected_port_words.size() != 0) begin
         report_mismatch($sformatf("%0d expected words never arrived",
                                   expected_port_words.size()));
      end
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/jafpe_pkg.sv
hdl/jafpe_req_if.sv
hdl/jafpe_rsp_if.sv
hdl/jafpe_rapid.sv
hdl/jafpe_encode.sv
hdl/joystick_autofire_port_encoder.sv
bench/tb_top.sv
